[hw/rtl/pfcr_pkg.sv]
package pfcr_pkg;

	typedef enum logic [1:0] {
		ST_CLEAN = 2'd0,
		ST_FIXED = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	localparam int unsigned STREAM_W   = 56;
	localparam int unsigned TOTAL_W    = 32;
	localparam logic [2:0]  LAST_SIX   = 3'd5;
	localparam logic [2:0]  LAST_SEVEN = 3'd6;
	localparam logic [2:0]  LEFT_FULL  = 3'd7;

	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic                seventh;
		status_t             status;
		logic [TOTAL_W-1:0]  detected;
		logic [TOTAL_W-1:0]  corrected;
		logic [TOTAL_W-1:0]  frames;
	} entry_t;

endpackage

[hw/rtl/pfcr_front.sv]
module pfcr_front #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [63:0]     frame,
	output pfcr_pkg::entry_t entry
);

	logic [7:0]             bad_row;
	logic [7:0]             colx;
	logic [2:0]             row_idx;
	logic [2:0]             col_idx;
	logic [3:0]             row_cnt;
	logic [3:0]             col_cnt;
	logic                   fix;
	pfcr_pkg::status_t      status;
	logic [63:0]            corr;
	logic [48:0]            data;
	logic [pfcr_pkg::STREAM_W-1:0] wide;
	logic [2:0]             left_cnt_q;
	logic [6:0]             left_bits_q;
	logic [2:0]             left_cnt_nx;
	logic [6:0]             left_mask;
	logic [COUNT_WIDTH-1:0] det_q;
	logic [COUNT_WIDTH-1:0] cor_q;
	logic [COUNT_WIDTH-1:0] frm_q;
	logic [COUNT_WIDTH-1:0] det_nx;
	logic [COUNT_WIDTH-1:0] cor_nx;
	logic [COUNT_WIDTH-1:0] frm_nx;

	always_comb begin
		colx    = '0;
		row_idx = '0;
		col_idx = '0;
		for (int j = 0; j < 8; j++) begin
			bad_row[j] = ^frame[63-8*j -: 8];
			colx       = colx ^ frame[63-8*j -: 8];
		end
		for (int j = 0; j < 8; j++) begin
			if (bad_row[j]) begin
				row_idx = row_idx | 3'(j);
			end
			if (colx[j]) begin
				col_idx = col_idx | 3'(j);
			end
		end
		row_cnt = 4'($countones(bad_row));
		col_cnt = 4'($countones(colx));
		fix     = (row_cnt == 4'd1) && (col_cnt == 4'd1);
		if (fix) begin
			status = pfcr_pkg::ST_FIXED;
		end else if ((row_cnt == 4'd0) && (col_cnt == 4'd0)) begin
			status = pfcr_pkg::ST_CLEAN;
		end else begin
			status = pfcr_pkg::ST_BAD;
		end
		corr = frame ^ (fix ? (64'd1 << {3'd7 - row_idx, col_idx}) : 64'd0);
		for (int j = 0; j < 7; j++) begin
			data[48-7*j -: 7] = corr[63-8*j -: 7];
		end
		wide = {left_bits_q, data} << (3'd7 - left_cnt_q);
		left_cnt_nx = (left_cnt_q == pfcr_pkg::LEFT_FULL) ? 3'd0 : left_cnt_q + 3'd1;
		left_mask   = ~(7'h7f << left_cnt_nx);
		det_nx = (status != pfcr_pkg::ST_CLEAN && det_q != '1) ? det_q + 1'b1 : det_q;
		cor_nx = (status == pfcr_pkg::ST_FIXED && cor_q != '1) ? cor_q + 1'b1 : cor_q;
		frm_nx = (frm_q != '1) ? frm_q + 1'b1 : frm_q;
	end

	always_comb begin
		entry.stream    = wide;
		entry.seventh   = (left_cnt_q == pfcr_pkg::LEFT_FULL);
		entry.status    = status;
		entry.detected  = pfcr_pkg::TOTAL_W'(det_nx);
		entry.corrected = pfcr_pkg::TOTAL_W'(cor_nx);
		entry.frames    = pfcr_pkg::TOTAL_W'(frm_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cnt_q  <= '0;
			left_bits_q <= '0;
			det_q       <= '0;
			cor_q       <= '0;
			frm_q       <= '0;
		end else if (push) begin
			left_cnt_q  <= left_cnt_nx;
			left_bits_q <= data[6:0] & left_mask;
			det_q       <= det_nx;
			cor_q       <= cor_nx;
			frm_q       <= frm_nx;
		end
	end

endmodule

[hw/rtl/pfcr_queue.sv]
module pfcr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pfcr_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output pfcr_pkg::entry_t head
);

	pfcr_pkg::entry_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/pfcr_back.sv]
module pfcr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  pfcr_pkg::entry_t head,
	output logic             pop,
	output logic             byte_valid,
	input  logic             byte_stall,
	output logic [7:0]       out_byte,
	output logic [1:0]       frame_status,
	output logic             last_of_frame,
	output logic [31:0]      detected_total,
	output logic [31:0]      corrected_total,
	output logic [31:0]      frames_total
);

	logic [2:0]                    idx_q;
	logic                          load;
	logic                          last;
	logic [pfcr_pkg::STREAM_W-1:0] shifted;

	assign load    = head_valid && (!byte_valid || !byte_stall);
	assign last    = head.seventh ? (idx_q == pfcr_pkg::LAST_SEVEN)
	                              : (idx_q == pfcr_pkg::LAST_SIX);
	assign pop     = load && last;
	assign shifted = head.stream << {idx_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			byte_valid <= 1'b0;
		end else begin
			if (load) begin
				idx_q      <= last ? 3'd0 : idx_q + 3'd1;
				byte_valid <= 1'b1;
			end else if (!byte_stall) begin
				byte_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte        <= shifted[pfcr_pkg::STREAM_W-1 -: 8];
			frame_status    <= head.status;
			last_of_frame   <= last;
			detected_total  <= head.detected;
			corrected_total <= head.corrected;
			frames_total    <= head.frames;
		end
	end

endmodule

[hw/rtl/parity_frame_correct_and_repack.sv]
// first byte of a word passes through a queue slot and then the registered byte output
// six bytes per word, seven on every eighth, one byte per cycle on the output while byte_stall is low
// the word rate is set by the single byte output
// the two-entry queue lets the input take words while bytes drain
// arst_n clears the queue, pack state, counters and output valid
module parity_frame_correct_and_repack #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [63:0] frame,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  frame_status,
	output logic        last_of_frame,
	output logic [31:0] detected_total,
	output logic [31:0] corrected_total,
	output logic [31:0] frames_total
);

	pfcr_pkg::entry_t wr_entry;
	pfcr_pkg::entry_t head;
	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;

	assign frame_stall = full;
	assign push        = frame_valid && !full;

	pfcr_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.frame  (frame),
		.entry  (wr_entry)
	);

	pfcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (wr_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	pfcr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.out_byte        (out_byte),
		.frame_status    (frame_status),
		.last_of_frame   (last_of_frame),
		.detected_total  (detected_total),
		.corrected_total (corrected_total),
		.frames_total    (frames_total)
	);

endmodule

[sim/pfcr_byte_checker.sv]
`timescale 1ns / 1ps

module pfcr_byte_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	input  logic        frame_stall,
	input  logic [63:0] frame,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  out_byte,
	input  logic [1:0]  frame_status,
	input  logic        last_of_frame,
	input  logic [31:0] detected_total,
	input  logic [31:0] corrected_total,
	input  logic [31:0] frames_total,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0]        data;
		pfcr_pkg::status_t status;
		logic              last;
		logic [31:0]       detected;
		logic [31:0]       corrected;
		logic [31:0]       frames;
	} packed_byte_t;

	packed_byte_t expected_bytes[$];

	logic [6:0]  carry_bits;
	int          carry_count;
	logic [31:0] detected_cnt;
	logic [31:0] corrected_cnt;
	logic [31:0] frame_cnt;

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == 32'hffff_ffff) ? c : c + 32'd1;
	endfunction

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch on %s: got %0h, want %0h", field, got, want);
		errors++;
	endtask

	task automatic predict_repacked_bytes(input logic [63:0] w);
		logic [7:0]        rows [8];
		logic [7:0]        colx;
		int                bad_rows;
		int                bad_cols;
		int                first_row;
		int                first_col;
		int                n;
		int                nres;
		pfcr_pkg::status_t st;
		logic [48:0]       data;
		logic [55:0]       acc;
		packed_byte_t      e;
		colx = '0;
		bad_rows = 0;
		bad_cols = 0;
		first_row = -1;
		first_col = -1;
		for (int j = 0; j < 8; j++) begin
			rows[j] = w[63 - 8 * j -: 8];
			colx ^= rows[j];
			if (^rows[j]) begin
				bad_rows++;
				if (first_row < 0) first_row = j;
			end
		end
		for (int b = 0; b < 8; b++) begin
			if (colx[b]) begin
				bad_cols++;
				if (first_col < 0) first_col = b;
			end
		end
		if (bad_rows == 1 && bad_cols == 1) begin
			st = pfcr_pkg::ST_FIXED;
			rows[first_row][first_col] = ~rows[first_row][first_col];
		end else if (bad_rows == 0 && bad_cols == 0) begin
			st = pfcr_pkg::ST_CLEAN;
		end else begin
			st = pfcr_pkg::ST_BAD;
		end
		if (st != pfcr_pkg::ST_CLEAN) detected_cnt = sat_inc(detected_cnt);
		if (st == pfcr_pkg::ST_FIXED) corrected_cnt = sat_inc(corrected_cnt);
		frame_cnt = sat_inc(frame_cnt);
		data = '0;
		for (int j = 0; j < 7; j++) begin
			data = {data[41:0], rows[j][7:1]};
		end
		acc = {carry_bits, data};
		n = carry_count + 49;
		nres = (carry_count == 7) ? 7 : 6;
		for (int k = 0; k < nres; k++) begin
			e.data = 8'(acc >> (n - 8 - 8 * k));
			e.status = st;
			e.last = (k == nres - 1);
			e.detected = detected_cnt;
			e.corrected = corrected_cnt;
			e.frames = frame_cnt;
			expected_bytes.push_back(e);
		end
		if (carry_count == 7) begin
			carry_bits = '0;
			carry_count = 0;
		end else begin
			carry_count++;
			carry_bits = 7'(acc & ((56'd1 << carry_count) - 56'd1));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_byte_t e;
		if (!arst_n) begin
			expected_bytes.delete();
			carry_bits = '0;
			carry_count = 0;
			detected_cnt = '0;
			corrected_cnt = '0;
			frame_cnt = '0;
			errors = 0;
			outstanding <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				if (expected_bytes.size() == 0) begin
					report("unexpected byte", 64'(out_byte), 64'd0);
				end else begin
					e = expected_bytes.pop_front();
					if (out_byte !== e.data)
						report("out_byte", 64'(out_byte), 64'(e.data));
					if (frame_status !== e.status)
						report("frame_status", 64'(frame_status), 64'(e.status));
					if (last_of_frame !== e.last)
						report("last_of_frame", 64'(last_of_frame), 64'(e.last));
					if (detected_total !== e.detected)
						report("detected_total", 64'(detected_total), 64'(e.detected));
					if (corrected_total !== e.corrected)
						report("corrected_total", 64'(corrected_total), 64'(e.corrected));
					if (frames_total !== e.frames)
						report("frames_total", 64'(frames_total), 64'(e.frames));
				end
			end
			if (frame_valid && !frame_stall) begin
				predict_repacked_bytes(frame);
			end
			outstanding <= expected_bytes.size();
		end
	end

endmodule

[sim/tb_parity_frame_correct_and_repack.sv]
`timescale 1ns / 1ps

module tb_parity_frame_correct_and_repack;

	localparam int RANDOM_FRAMES = 470;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk;
	logic        arst_n;
	logic        frame_valid;
	logic        frame_stall;
	logic [63:0] frame;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  out_byte;
	logic [1:0]  frame_status;
	logic        last_of_frame;
	logic [31:0] detected_total;
	logic [31:0] corrected_total;
	logic [31:0] frames_total;
	int          errors;
	int          outstanding;
	int          cycles = 0;
	bit          tx_calm;
	bit          rx_calm;

	parity_frame_correct_and_repack #(
		.COUNT_WIDTH(32)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame          (frame),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.out_byte       (out_byte),
		.frame_status   (frame_status),
		.last_of_frame  (last_of_frame),
		.detected_total (detected_total),
		.corrected_total(corrected_total),
		.frames_total   (frames_total)
	);

	pfcr_byte_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame          (frame),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.out_byte       (out_byte),
		.frame_status   (frame_status),
		.last_of_frame  (last_of_frame),
		.detected_total (detected_total),
		.corrected_total(corrected_total),
		.frames_total   (frames_total),
		.errors         (errors),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [63:0] encode_frame(input logic [48:0] d);
		logic [63:0] w;
		logic [7:0]  r;
		logic [7:0]  cols;
		cols = '0;
		for (int j = 0; j < 7; j++) begin
			r[7:1] = d[48 - 7 * j -: 7];
			r[0] = ^r[7:1];
			w[63 - 8 * j -: 8] = r;
			cols ^= r;
		end
		w[7:0] = cols;
		return w;
	endfunction

	function automatic logic [48:0] rand_data();
		return 49'({$urandom, $urandom});
	endfunction

	function automatic logic [63:0] flip_bits(input logic [63:0] w, input int count);
		for (int i = 0; i < count; i++) begin
			w[$urandom_range(0, 63)] ^= 1'b1;
		end
		return w;
	endfunction

	// one word offered per call, valid kept high across back-to-back words
	task automatic send_frame(input logic [63:0] w);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame <= w;
		do @(posedge clk); while (frame_stall);
	endtask

	initial begin
		int rx_count;
		int waits;
		rx_count = 0;
		byte_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_count % 48 == 0) rx_calm = ($urandom_range(0, 3) == 0);
			waits = rx_calm ? 0 : $urandom_range(0, 8);
			if (waits > 0) begin
				byte_stall <= 1'b1;
				repeat (waits) @(posedge clk);
				byte_stall <= 1'b0;
			end
			do @(posedge clk); while (!byte_valid);
			rx_count++;
		end
	end

	initial begin
		logic [63:0] base;
		logic [63:0] w;
		int          pick;
		arst_n <= 1'b0;
		frame_valid <= 1'b0;
		frame <= '0;
		tx_calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// clean, all ones, single data-bit and parity-bit errors, multi-bit patterns
		send_frame(64'h0);
		send_frame(64'hffff_ffff_ffff_ffff);
		send_frame(encode_frame('1));
		base = encode_frame(rand_data());
		send_frame(base);
		send_frame(base ^ 64'h8000_0000_0000_0000);
		send_frame(base ^ 64'h0100_0000_0000_0000);
		send_frame(base ^ 64'h0000_0000_0000_0080);
		send_frame(base ^ 64'h0000_0000_0000_0001);
		send_frame(base ^ 64'h0000_0000_0000_0200);
		send_frame(base ^ 64'h0000_0000_0012_0000);
		send_frame(base ^ 64'h0000_1000_0010_0000);
		send_frame(base ^ 64'h0004_0000_2000_0000);
		send_frame(base ^ 64'h0240_0000_0000_8000);
		send_frame(base ^ 64'h0000_0a00_0a00_0000);
		send_frame(encode_frame(rand_data()) ^ 64'h0000_0000_4000_0000);
		send_frame(64'h0123_4567_89ab_cdef);
		send_frame(64'h8000_0000_0000_0000);
		send_frame(64'h0000_0000_0000_0001);
		send_frame(64'haaaa_aaaa_aaaa_aaaa);
		send_frame(64'h5555_5555_5555_5555);
		send_frame(encode_frame(49'h1));
		send_frame(encode_frame(49'h1_0000_0000_0000));

		for (int i = 0; i < RANDOM_FRAMES; i++) begin
			if (i % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			base = encode_frame(rand_data());
			if (pick < 30) w = base;
			else if (pick < 65) w = flip_bits(base, 1);
			else if (pick < 85) w = flip_bits(base, $urandom_range(2, 5));
			else w = {$urandom, $urandom};
			send_frame(w);
		end
		frame_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pfcr_pkg.sv
hw/rtl/pfcr_front.sv
hw/rtl/pfcr_queue.sv
hw/rtl/pfcr_back.sv
hw/rtl/parity_frame_correct_and_repack.sv
sim/pfcr_byte_checker.sv
sim/tb_parity_frame_correct_and_repack.sv
